/* rtl/pipct_pkg.sv */
// Shared types and codes for the point-in-polygon crossing test unit.
// Stand-alone package, no dependencies.
package pipct_pkg;

	localparam int COORD_W = 32;
	localparam int LABEL_W = 8;
	localparam int ACT_W   = 2;

	// Action codes of an input transaction
	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

	// One stored polygon edge, signed Q16.16 coordinates
	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
	} edge_t;

	// Coordinate difference and exact cross product
	typedef logic signed [COORD_W:0]       diff_t;
	typedef logic signed [2*COORD_W+1:0]   prod_t;

endpackage

/* rtl/point_in_polygon_crossing_test_unit.sv */
// Even-odd point-in-polygon test over an edge table held in one synchronous RAM.
// Depends on pipct_pkg for the edge record, action codes and arithmetic types.
//
//  channel  | signals                                               | direction
//  ---------+-------------------------------------------------------+----------
//  command  | start, busy, action, start_x/y, end_x/y, point_x/y    | in; busy out
//  result   | done, is_inside, region_out, table_full               | out
//  config   | cfg_wr_en, cfg_wr_data (region label)                 | in
//
// Add, clear and unused codes do not enter the query state; their result strobes in the cycle after acceptance.
// A query walks the table: the RAM read port
// delivers one edge per cycle into a three-stage difference/multiply/compare pipe.
// busy is high while a query walks the table; results cannot be stalled.
// arst_n clears the edge count, the label, the controller and the result strobe.
module point_in_polygon_crossing_test_unit #(
	parameter int MAX_EDGES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [pipct_pkg::ACT_W-1:0]           action,
	input  logic signed [pipct_pkg::COORD_W-1:0]  start_x,
	input  logic signed [pipct_pkg::COORD_W-1:0]  start_y,
	input  logic signed [pipct_pkg::COORD_W-1:0]  end_x,
	input  logic signed [pipct_pkg::COORD_W-1:0]  end_y,
	input  logic signed [pipct_pkg::COORD_W-1:0]  point_x,
	input  logic signed [pipct_pkg::COORD_W-1:0]  point_y,
	output logic                                  done,
	output logic                                  is_inside,
	output logic [pipct_pkg::LABEL_W-1:0]         region_out,
	output logic                                  table_full,
	input  logic                                  cfg_wr_en,
	input  logic [pipct_pkg::LABEL_W-1:0]         cfg_wr_data
);

	localparam int AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CNT_W = $clog2(MAX_EDGES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EDGES);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_QUERY = 1'b1;

	logic                                  state_q;
	logic [CNT_W-1:0]                      edge_count_q;
	logic [CNT_W-1:0]                      issue_cnt_q;
	logic [pipct_pkg::LABEL_W-1:0]         region_label_q;
	logic signed [pipct_pkg::COORD_W-1:0]  px_q;
	logic signed [pipct_pkg::COORD_W-1:0]  py_q;
	logic                                  parity_q;

	logic                                  accept;
	logic                                  rd_en;
	logic                                  wr_en;
	logic                                  finish;

	pipct_pkg::edge_t                      mem [MAX_EDGES];
	pipct_pkg::edge_t                      rd_data_s1;
	logic                                  v_s1;

	pipct_pkg::diff_t                      dex_s2, dey_s2, dpy_s2, dpx_s2;
	logic                                  cand_s2, dypos_s2, v_s2;
	pipct_pkg::diff_t                      dex, dey, dpy, dpx;
	logic                                  straddle, left_ok;

	pipct_pkg::prod_t                      lhs_s3, rhs_s3;
	logic                                  cand_s3, dypos_s3, v_s3;
	logic                                  toggle;

	logic                                  done_q, inside_q, full_q;
	logic [pipct_pkg::LABEL_W-1:0]         region_q;

	assign busy   = (state_q == ST_QUERY);
	assign accept = start && !busy;
	assign wr_en  = accept && (action == pipct_pkg::ACT_ADD) && (edge_count_q < CNT_MAX);
	assign rd_en  = (state_q == ST_QUERY) && (issue_cnt_q < edge_count_q);
	assign finish = (state_q == ST_QUERY) && !rd_en && !v_s1 && !v_s2 && !v_s3;

	// Hold the region label
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_label_q <= '0;
		end else if (cfg_wr_en) begin
			region_label_q <= cfg_wr_data;
		end
	end

	// Edge table RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[edge_count_q[AW-1:0]] <= '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[issue_cnt_q[AW-1:0]];
		end
	end

	// Track the edge count and the query controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			edge_count_q <= '0;
			issue_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							pipct_pkg::ACT_ADD: begin
								if (wr_en) begin
									edge_count_q <= edge_count_q + CNT_W'(1);
								end
							end
							pipct_pkg::ACT_CLEAR: begin
								edge_count_q <= '0;
							end
							pipct_pkg::ACT_QUERY: begin
								issue_cnt_q <= '0;
								state_q     <= ST_QUERY;
							end
							default: ;
						endcase
					end
				end
				ST_QUERY: begin
					if (rd_en) begin
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the query point
	always_ff @(posedge clk) begin
		if (accept && (action == pipct_pkg::ACT_QUERY)) begin
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	// Stage 2: differences and straddle / left-of-point tests
	always_comb begin
		dex      = pipct_pkg::diff_t'(rd_data_s1.ex) - pipct_pkg::diff_t'(rd_data_s1.sx);
		dey      = pipct_pkg::diff_t'(rd_data_s1.ey) - pipct_pkg::diff_t'(rd_data_s1.sy);
		dpy      = pipct_pkg::diff_t'(py_q) - pipct_pkg::diff_t'(rd_data_s1.sy);
		dpx      = pipct_pkg::diff_t'(px_q) - pipct_pkg::diff_t'(rd_data_s1.sx);
		straddle = ((rd_data_s1.sy < py_q) && (rd_data_s1.ey >= py_q)) ||
		           ((rd_data_s1.ey < py_q) && (rd_data_s1.sy >= py_q));
		left_ok  = (rd_data_s1.sx <= px_q) || (rd_data_s1.ex <= px_q);
	end

	always_ff @(posedge clk) begin
		dex_s2   <= dex;
		dey_s2   <= dey;
		dpy_s2   <= dpy;
		dpx_s2   <= dpx;
		cand_s2  <= straddle && left_ok;
		dypos_s2 <= !dey[pipct_pkg::COORD_W];
		// Stage 3: exact cross products
		lhs_s3   <= pipct_pkg::prod_t'(dpy_s2) * pipct_pkg::prod_t'(dex_s2);
		rhs_s3   <= pipct_pkg::prod_t'(dpx_s2) * pipct_pkg::prod_t'(dey_s2);
		cand_s3  <= cand_s2;
		dypos_s3 <= dypos_s2;
	end

	// Advance the pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Crossing x lies left of the point; flip the compare when dy is negative
	assign toggle = v_s3 && cand_s3 && (dypos_s3 ? (lhs_s3 < rhs_s3) : (rhs_s3 < lhs_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (accept && (action == pipct_pkg::ACT_QUERY)) begin
			parity_q <= 1'b0;
		end else if (toggle) begin
			parity_q <= !parity_q;
		end
	end

	// Result transaction: one-cycle strobe with registered fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (action != pipct_pkg::ACT_QUERY)) || finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (action != pipct_pkg::ACT_QUERY)) begin
			inside_q <= 1'b0;
			region_q <= '0;
			full_q   <= (action == pipct_pkg::ACT_ADD) && !wr_en;
		end else if (finish) begin
			inside_q <= parity_q;
			region_q <= parity_q ? region_label_q : '0;
			full_q   <= 1'b0;
		end
	end

	assign done       = done_q;
	assign is_inside  = inside_q;
	assign region_out = region_q;
	assign table_full = full_q;

`ifndef SYNTHESIS
	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == pipct_pkg::ACT_QUERY)) |=> busy)
		else $error("query accepted but unit not busy");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= CNT_MAX)
		else $error("edge count beyond table depth");

	a_pipe_only_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3) |-> busy)
		else $error("edge pipeline active outside a query");

	a_outside_no_label: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_inside) |-> (region_out == '0))
		else $error("region label reported for outside point");

	a_full_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full) |-> !is_inside)
		else $error("rejected add reported inside");
`endif

endmodule

/* tb/tb_point_in_polygon_crossing_test_unit.sv */
`timescale 1ns / 100ps
// Testbench for point_in_polygon_crossing_test_unit: add, clear and query transactions
// checked one by one against an even-odd crossing predictor kept inside the bench.
// Depends on pipct_pkg and the unit's RTL only.
module tb_point_in_polygon_crossing_test_unit;

	typedef logic signed [pipct_pkg::COORD_W-1:0] coord_t;
	typedef logic [pipct_pkg::ACT_W-1:0]          act_t;
	typedef logic [pipct_pkg::LABEL_W-1:0]        label_t;

	localparam int TABLE_DEPTH = 64;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam act_t ACT_UNUSED = 2'd3;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t UNIT = 32'sh0001_0000;
	localparam int STYLE_GRID = 0;
	localparam int STYLE_WIDE = 1;
	localparam int STYLE_CORNER = 2;

	typedef struct packed {
		logic   in_poly;
		label_t region;
		logic   full;
	} verdict_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	act_t    action = pipct_pkg::ACT_ADD;
	coord_t  start_x = '0;
	coord_t  start_y = '0;
	coord_t  end_x = '0;
	coord_t  end_y = '0;
	coord_t  point_x = '0;
	coord_t  point_y = '0;
	logic    done;
	logic    is_inside;
	label_t  region_out;
	logic    table_full;
	logic    cfg_wr_en = 1'b0;
	label_t  cfg_wr_data = '0;

	// Predictor state
	pipct_pkg::edge_t polygon_edges [TABLE_DEPTH];
	int unsigned    edge_total = 0;
	label_t         label_reg = '0;
	verdict_t       verdict_q [$];

	int unsigned    error_count = 0;
	int unsigned    items_sent = 0;
	int             idle_pct = 0;

	point_in_polygon_crossing_test_unit #(
		.MAX_EDGES(TABLE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.point_x    (point_x),
		.point_y    (point_y),
		.done       (done),
		.is_inside  (is_inside),
		.region_out (region_out),
		.table_full (table_full),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decide whether one edge flips parity for the leftward ray from the point
	function automatic logic crosses_ray(input pipct_pkg::edge_t e, input coord_t px,
			input coord_t py);
		logic signed [2*pipct_pkg::COORD_W+3:0] ax, ay, bx, by, qx, qy, dy, lhs, rhs;
		ax = $signed(e.sx);
		ay = $signed(e.sy);
		bx = $signed(e.ex);
		by = $signed(e.ey);
		qx = px;
		qy = py;
		if (!((ay < qy && by >= qy) || (by < qy && ay >= qy)))
			return 1'b0;
		if (!(ax <= qx || bx <= qx))
			return 1'b0;
		// exact crossing-x test, orientation follows the sign of dy
		dy = by - ay;
		lhs = (qy - ay) * (bx - ax);
		rhs = (qx - ax) * dy;
		return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
	endfunction

	// Advance the predicted table and produce the expected result of one transaction
	function automatic verdict_t predict_verdict(input act_t act, input pipct_pkg::edge_t e,
			input coord_t px, input coord_t py);
		verdict_t v;
		logic parity;
		v = '0;
		parity = 1'b0;
		case (act)
			pipct_pkg::ACT_ADD: begin
				if (edge_total < TABLE_DEPTH) begin
					polygon_edges[edge_total] = e;
					edge_total++;
				end else begin
					v.full = 1'b1;
				end
			end
			pipct_pkg::ACT_CLEAR: begin
				edge_total = 0;
			end
			pipct_pkg::ACT_QUERY: begin
				for (int i = 0; i < edge_total; i++)
					if (crosses_ray(polygon_edges[i], px, py))
						parity = ~parity;
				if (parity) begin
					v.in_poly = 1'b1;
					v.region = label_reg;
				end
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// Append one expected result behind the ones still pending
	function automatic void enqueue_verdict(input verdict_t v);
		verdict_q.insert(verdict_q.size(), v);
	endfunction

	function automatic coord_t pick_corner();
		case ($urandom_range(6))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return C_MIN + 32'sd1;
			default: return C_MAX - 32'sd1;
		endcase
	endfunction

	function automatic coord_t pick_coord(input int style, input int shift, input coord_t base);
		int g;
		case (style)
			STYLE_GRID: begin
				g = int'($urandom_range(16)) - 8;
				return base + (g <<< shift);
			end
			STYLE_WIDE: return $urandom;
			default: return pick_corner();
		endcase
	endfunction

	function automatic pipct_pkg::edge_t rand_edge();
		return '{$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Drive one transaction, hold it until accepted, then record its expected result
	task automatic send_cmd(input act_t act, input pipct_pkg::edge_t e,
			input coord_t px, input coord_t py);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		start_x <= e.sx;
		start_y <= e.sy;
		end_x <= e.ex;
		end_y <= e.ey;
		point_x <= px;
		point_y <= py;
		do
			@(posedge clk);
		while (busy);
		enqueue_verdict(predict_verdict(act, e, px, py));
		items_sent++;
	endtask

	task automatic add_edge(input coord_t ax, input coord_t ay, input coord_t bx,
			input coord_t by);
		send_cmd(pipct_pkg::ACT_ADD, '{ax, ay, bx, by}, $urandom, $urandom);
	endtask

	task automatic query_point(input coord_t px, input coord_t py);
		send_cmd(pipct_pkg::ACT_QUERY, rand_edge(), px, py);
	endtask

	// Write the label only once the unit has drained
	task automatic set_region_label(input label_t value);
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		label_reg = value;
	endtask

	task automatic test_empty_table();
		set_region_label(8'hFF);
		query_point('0, '0);
		query_point(C_MIN, C_MAX);
		send_cmd(pipct_pkg::ACT_CLEAR, rand_edge(), $urandom, $urandom);
		send_cmd(ACT_UNUSED, rand_edge(), $urandom, $urandom);
		query_point(C_MAX, C_MIN);
	endtask

	// Axis-aligned square with horizontal edges; probe interior, exterior, border and corners
	task automatic test_square();
		send_cmd(pipct_pkg::ACT_CLEAR, rand_edge(), $urandom, $urandom);
		add_edge('0, '0, 4 * UNIT, '0);
		add_edge(4 * UNIT, '0, 4 * UNIT, 4 * UNIT);
		add_edge(4 * UNIT, 4 * UNIT, '0, 4 * UNIT);
		add_edge('0, 4 * UNIT, '0, '0);
		query_point(2 * UNIT, 2 * UNIT);
		query_point(-UNIT, 2 * UNIT);
		query_point(5 * UNIT, 2 * UNIT);
		query_point('0, 2 * UNIT);
		query_point(4 * UNIT, 2 * UNIT);
		query_point('0, '0);
		query_point(2 * UNIT, 4 * UNIT);
		query_point(2 * UNIT, '0);
		send_cmd(ACT_UNUSED, rand_edge(), 2 * UNIT, 2 * UNIT);
		query_point(2 * UNIT - 1, 4 * UNIT - 1);
	endtask

	// Full-range clockwise triangle, then an extra edge with rising y
	task automatic test_extreme_triangle();
		send_cmd(pipct_pkg::ACT_CLEAR, rand_edge(), $urandom, $urandom);
		add_edge(C_MIN, C_MIN, C_MIN, C_MAX);
		add_edge(C_MIN, C_MAX, C_MAX, C_MAX);
		add_edge(C_MAX, C_MAX, C_MIN, C_MIN);
		query_point(-32'sd5, 32'sd5);
		query_point(32'sd5, -32'sd5);
		query_point(C_MIN, '0);
		query_point(C_MAX, C_MAX);
		query_point(C_MIN, C_MIN);
		add_edge(C_MAX, C_MIN, C_MIN, C_MAX);
		query_point(-32'sd5, 32'sd5);
		query_point(C_MAX, C_MAX - 1);
		set_region_label(8'h00);
		query_point(C_MIN + 1, C_MAX);
	endtask

	// Fill the table, overflow it, then recover with a clear
	task automatic test_table_full();
		set_region_label(8'h5A);
		send_cmd(pipct_pkg::ACT_CLEAR, rand_edge(), $urandom, $urandom);
		repeat (TABLE_DEPTH)
			send_cmd(pipct_pkg::ACT_ADD, rand_edge(), $urandom, $urandom);
		send_cmd(pipct_pkg::ACT_ADD, rand_edge(), $urandom, $urandom);
		add_edge(C_MIN, C_MIN, C_MAX, C_MAX);
		query_point($urandom, $urandom);
		query_point('0, '0);
		send_cmd(pipct_pkg::ACT_CLEAR, rand_edge(), $urandom, $urandom);
		send_cmd(pipct_pkg::ACT_ADD, rand_edge(), $urandom, $urandom);
		query_point($urandom, $urandom);
	endtask

	// One closed polygon with random content, a few damaged edges, then queries on it
	task automatic run_polygon_round();
		coord_t vx [0:71];
		coord_t vy [0:71];
		coord_t px, py;
		coord_t base;
		int n, style, shift, k, k1, pick;
		pick = $urandom_range(99);
		style = (pick < 70) ? STYLE_GRID : (pick < 85) ? STYLE_WIDE : STYLE_CORNER;
		shift = ($urandom_range(3) == 0) ? $urandom_range(30) : 16;
		base = ($urandom_range(3) == 0) ? $urandom : '0;
		n = ($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(3, 10);
		for (int i = 0; i < n; i++) begin
			vx[i] = pick_coord(style, shift, base);
			vy[i] = pick_coord(style, shift, base);
		end
		if ($urandom_range(3) != 0)
			send_cmd(pipct_pkg::ACT_CLEAR, rand_edge(), $urandom, $urandom);
		for (int i = 0; i < n; i++) begin
			k1 = (i + 1) % n;
			pick = $urandom_range(99);
			if (pick < 3)
				continue;
			else if (pick < 8)
				add_edge(vx[i], vy[i], pick_coord(STYLE_WIDE, 0, '0), vy[k1]);
			else
				add_edge(vx[i], vy[i], vx[k1], vy[k1]);
		end
		repeat ($urandom_range(2, 8)) begin
			k = $urandom_range(n - 1);
			k1 = (k + 1) % n;
			case ($urandom_range(4))
				0: begin
					px = vx[k];
					py = vy[k];
				end
				1: begin
					px = (vx[k] >>> 1) + (vx[k1] >>> 1);
					py = (vy[k] >>> 1) + (vy[k1] >>> 1);
				end
				2: begin
					px = vx[k] + int'($urandom_range(2)) - 1;
					py = vy[k];
				end
				3: begin
					px = pick_coord(STYLE_WIDE, 0, '0);
					py = pick_coord(STYLE_WIDE, 0, '0);
				end
				default: begin
					px = pick_coord(style, shift, base);
					py = pick_coord(style, shift, base);
				end
			endcase
			query_point(px, py);
		end
	endtask

	task automatic test_random_traffic(input int pct, input int count, input label_t label);
		int unsigned target;
		idle_pct = pct;
		set_region_label(label);
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(99) < 15)
				send_cmd(act_t'($urandom_range(3)), rand_edge(), $urandom, $urandom);
			else
				run_polygon_round();
		end
	endtask

	task automatic report_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	// Check each result strobe against the oldest expectation
	always @(posedge clk) begin : check_result
		verdict_t want;
		if (done) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual inside %0b region %0h full %0b",
					$time, is_inside, region_out, table_full);
				error_count++;
			end else begin
				want = verdict_q.pop_front();
				report_field("is_inside", want.in_poly, is_inside);
				report_field("region_out", want.region, region_out);
				report_field("table_full", want.full, table_full);
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 26;
		test_empty_table();
		test_square();
		test_extreme_triangle();
		test_table_full();
		test_random_traffic(26, 660, 8'hFF);
		test_random_traffic(76, 660, 8'($urandom));
		test_random_traffic(0, 680, 8'($urandom));
		// drain and let the pipe settle
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_point_in_polygon_crossing_test_unit: done, clean");
		else
			$display("tb_point_in_polygon_crossing_test_unit: done, errors");
		$finish;
	end

	// Hang guard
	initial begin
		#20_000_000;
		$display("tb_point_in_polygon_crossing_test_unit: done, errors");
		$finish;
	end

endmodule

/* point_in_polygon_crossing_test_unit.f */
rtl/pipct_pkg.sv
rtl/point_in_polygon_crossing_test_unit.sv
tb/tb_point_in_polygon_crossing_test_unit.sv
